// ===== hw/rtl/actm_pkg.sv =====
// shared types and constants of the token matcher
package actm_pkg;

  localparam int NODE_W = 12;
  localparam int TOK_W  = 6;
  localparam int LEN_W  = 8;
  localparam int POS_W  = 10;
  localparam int POS_FIELD_MAX = 1023;

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  // request type codes
  localparam logic [1:0] REQ_GOTO_WR = 2'd0;
  localparam logic [1:0] REQ_NODE_WR = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;
  localparam logic [1:0] REQ_SEARCH  = 2'd3;

  typedef enum logic [2:0] {
    OP_GOTO_WR,
    OP_NODE_WR,
    OP_START,
    OP_PASS,
    OP_SEARCH
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] node_index;
    logic [TOK_W-1:0]  token_code;
    logic [NODE_W-1:0] next_node;
    logic [NODE_W-1:0] fail_node;
    logic [LEN_W-1:0]  match_length;
  } in_item_t;

  typedef struct packed {
    logic              match_found;
    logic [POS_W-1:0]  end_position;
    logic [LEN_W-1:0]  mark_count;
    logic [NODE_W-1:0] current_node;
  } out_item_t;

  typedef struct packed {
    cmd_op_e           op;
    logic              tok_ok;
    logic [NODE_W-1:0] node_index;
    logic [TOK_W-1:0]  token_code;
    logic [NODE_W-1:0] next_node;
    logic [NODE_W-1:0] fail_node;
    logic [LEN_W-1:0]  match_length;
    logic [POS_W-1:0]  end_position;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] fail_node;
    logic [LEN_W-1:0]  match_length;
  } node_ent_t;

endpackage

// ===== hw/rtl/actm_front.sv =====
// front end: takes requests, tracks line position and limiter skipping, decodes commands
module actm_front #(
  parameter int NODE_COUNT  = 4096,
  parameter int TOKEN_COUNT = 64,
  parameter int LINE_LENGTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  actm_pkg::in_item_t       in_data_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [actm_pkg::TOK_W-1:0] cfg_data_i,
  input  logic                     full_i,
  output logic                     push_o,
  output actm_pkg::cmd_t           cmd_o
);
  import actm_pkg::*;

  localparam int PosLimInt = (LINE_LENGTH - 1 > POS_FIELD_MAX) ? POS_FIELD_MAX : LINE_LENGTH - 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PosLimInt);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             skip_q, skip_d;
  logic [TOK_W-1:0] limiter_q;
  logic             accept;
  logic             node_ok, tok_ok, lim_ok;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = accept;

  assign node_ok = 32'(in_data_i.node_index) < NODE_COUNT;
  assign tok_ok  = 32'(in_data_i.token_code) < TOKEN_COUNT;
  assign lim_ok  = 32'(limiter_q) < TOKEN_COUNT;

  always_comb begin
    pos_d  = pos_q;
    skip_d = skip_q;
    cmd_o.op           = OP_PASS;
    cmd_o.tok_ok       = tok_ok;
    cmd_o.node_index   = in_data_i.node_index;
    cmd_o.token_code   = in_data_i.token_code;
    cmd_o.next_node    = in_data_i.next_node;
    cmd_o.fail_node    = in_data_i.fail_node;
    cmd_o.match_length = in_data_i.match_length;
    cmd_o.end_position = pos_q;
    case (in_data_i.req_type)
      REQ_GOTO_WR: begin
        if (node_ok && tok_ok) cmd_o.op = OP_GOTO_WR;
      end
      REQ_NODE_WR: begin
        if (node_ok) cmd_o.op = OP_NODE_WR;
      end
      REQ_START: begin
        cmd_o.op           = OP_START;
        cmd_o.token_code   = limiter_q;
        cmd_o.tok_ok       = lim_ok;
        cmd_o.end_position = '0;
        pos_d              = '0;
        skip_d             = 1'b1;
      end
      REQ_SEARCH: begin
        if (pos_q < POS_LIMIT) pos_d = pos_q + POS_W'(1);
        // leading limiters only move the position
        if (!(skip_q && in_data_i.token_code == limiter_q)) begin
          cmd_o.op = OP_SEARCH;
          skip_d   = 1'b0;
        end
      end
      default: cmd_o.op = OP_PASS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      skip_q    <= 1'b1;
      limiter_q <= '0;
    end else begin
      if (accept) begin
        pos_q  <= pos_d;
        skip_q <= skip_d;
      end
      if (cfg_valid_i) limiter_q <= cfg_data_i;
    end
  end

endmodule

// ===== hw/rtl/actm_fifo.sv =====
// two-entry command queue between front end and automaton walker
module actm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  actm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output actm_pkg::cmd_t head_o
);
  import actm_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/actm_back.sv =====
// back end: automaton tables, fail-link walker and result register
module actm_back #(
  parameter int NODE_COUNT  = 4096,
  parameter int TOKEN_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  actm_pkg::cmd_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output actm_pkg::out_item_t out_data_o
);
  import actm_pkg::*;

  localparam int GDEPTH = NODE_COUNT * TOKEN_COUNT;
  localparam int GA_W   = $clog2(GDEPTH);
  localparam int NA_W   = $clog2(NODE_COUNT);
  localparam int SW     = $clog2(NODE_COUNT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [NODE_W-1:0] goto_mem [GDEPTH];
  node_ent_t         node_mem [NODE_COUNT];

  logic [2:0]        state_q, state_d;
  logic [NODE_W-1:0] node_q;
  logic [NODE_W-1:0] q_q, q_d;
  logic [SW-1:0]     steps_q, steps_d;
  logic [NODE_W-1:0] res_node_q, res_node_d;
  logic              res_ok_q, res_ok_d;
  logic [NODE_W-1:0] goto_rd_q;
  node_ent_t         node_rd_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              can_emit, emit, goto_we, node_we;
  out_item_t         emit_data;
  logic [NODE_W-1:0] ga_node, na_node;
  logic [GA_W-1:0]   ga_rd, ga_wr;
  logic [NA_W-1:0]   na_rd, na_wr;
  logic              q_ok, g_ok;
  logic [LEN_W-1:0]  len;

  assign can_emit = !out_valid_q || out_ready_i;
  assign q_ok     = 32'(q_q) < NODE_COUNT;
  assign g_ok     = 32'(goto_rd_q) < NODE_COUNT;
  assign len      = res_ok_q ? node_rd_q.match_length : '0;

  // read addresses stay put while a state waits on the output
  assign ga_node = (state_q == ST_READ) ? q_q : ROOT_NODE;
  assign ga_rd   = GA_W'(ga_node) * GA_W'(TOKEN_COUNT) + GA_W'(head_i.token_code);
  assign ga_wr   = GA_W'(head_i.node_index) * GA_W'(TOKEN_COUNT) + GA_W'(head_i.token_code);

  always_comb begin
    case (state_q)
      ST_READ: na_node = q_q;
      ST_EVAL: na_node = goto_rd_q;
      default: na_node = res_node_q;
    endcase
  end
  assign na_rd = NA_W'(na_node);
  assign na_wr = NA_W'(head_i.node_index);

  always_ff @(posedge clk_i) begin
    if (goto_we) goto_mem[ga_wr] <= head_i.next_node;
    goto_rd_q <= goto_mem[ga_rd];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[na_wr] <= '{fail_node: head_i.fail_node,
                                      match_length: head_i.match_length};
    node_rd_q <= node_mem[na_rd];
  end

  always_comb begin
    state_d    = state_q;
    q_d        = q_q;
    steps_d    = steps_q;
    res_node_d = res_node_q;
    res_ok_d   = res_ok_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    goto_we    = 1'b0;
    node_we    = 1'b0;
    emit_data.match_found  = 1'b0;
    emit_data.end_position = head_i.end_position;
    emit_data.mark_count   = '0;
    emit_data.current_node = node_q;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_GOTO_WR: begin
              if (can_emit) begin
                goto_we = 1'b1;
                emit    = 1'b1;
                pop_o   = 1'b1;
              end
            end
            OP_NODE_WR: begin
              if (can_emit) begin
                node_we = 1'b1;
                emit    = 1'b1;
                pop_o   = 1'b1;
              end
            end
            OP_START: state_d = ST_START;
            OP_SEARCH: begin
              if (head_i.tok_ok) begin
                q_d     = node_q;
                steps_d = '0;
                state_d = ST_READ;
              end else if (can_emit) begin
                // no goto exists for this token anywhere
                emit_data.current_node = ROOT_NODE;
                emit  = 1'b1;
                pop_o = 1'b1;
              end
            end
            default: begin
              if (can_emit) begin
                emit  = 1'b1;
                pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      ST_START: begin
        if (can_emit) begin
          emit_data.current_node = head_i.tok_ok ? goto_rd_q : '0;
          emit    = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (q_q == '0 || !q_ok) begin
          res_node_d = ROOT_NODE;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (goto_rd_q != '0) begin
          res_node_d = goto_rd_q;
          res_ok_d   = g_ok;
          state_d    = ST_LEN;
        end else if (steps_q >= SW'(NODE_COUNT)) begin
          // fail chain runs in a cycle
          res_node_d = ROOT_NODE;
          state_d    = ST_EMIT;
        end else begin
          q_d     = node_rd_q.fail_node;
          steps_d = steps_q + SW'(1);
          state_d = ST_READ;
        end
      end
      ST_LEN: begin
        if (can_emit) begin
          emit_data.current_node = res_node_q;
          emit_data.match_found  = len != '0;
          emit_data.mark_count   = (len > LEN_W'(2)) ? len - LEN_W'(2) : '0;
          emit    = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          emit_data.current_node = res_node_q;
          emit    = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= ROOT_NODE;
      q_q         <= '0;
      steps_q     <= '0;
      res_node_q  <= '0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      q_q        <= q_d;
      steps_q    <= steps_d;
      res_node_q <= res_node_d;
      res_ok_q   <= res_ok_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        node_q      <= emit_data.current_node;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= emit_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("pop with empty queue");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> head_valid_i)
    else $error("walker busy without a command");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= SW'(NODE_COUNT))
    else $error("fail walk exceeded step bound");

  a_goto_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LEN |-> res_node_q != '0)
    else $error("taken goto is zero");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit && pop_o)
    else $error("result emitted without free slot or pop");

endmodule

// ===== hw/rtl/aho_corasick_token_matcher.sv =====
// top level of the token matcher: front end, command queue and automaton walker
//
// Usage: every request on the in channel (valid/ready) gives exactly one result on the
// out channel (valid/ready), in order. Requests either load the automaton (goto entry,
// or fail link and match length of a node), start a line, or search one token.
// The cfg channel writes the limiter token; write it only while no request is in flight.
// The front end takes a request every cycle while the two-entry command queue has room;
// the walker then handles one command at a time:
//   load and skipped requests: handled directly from the idle state of the walker
//   start line: goto table read of the root
//   search: read, evaluate and match-length states on a direct goto, plus a read and
//   an evaluate state per fail link followed; the fail-link walk, one table read pair
//   per link, sets the rate
// Reset puts the automaton at the root, line position at zero and skipping of leading
// limiters on; table contents are undefined until loaded. When the receiver stalls the
// result stays in the output register, the walker holds, and the queue fills and then
// drops in_ready_o.
module aho_corasick_token_matcher #(
  parameter int NODE_COUNT  = 4096,
  parameter int TOKEN_COUNT = 64,
  parameter int LINE_LENGTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  actm_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output actm_pkg::out_item_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [actm_pkg::TOK_W-1:0] cfg_data_i
);
  import actm_pkg::*;

  logic full, push, pop, head_valid;
  cmd_t cmd, head;

  actm_front #(
    .NODE_COUNT (NODE_COUNT),
    .TOKEN_COUNT(TOKEN_COUNT),
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  actm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .head_o (head)
  );

  actm_back #(
    .NODE_COUNT (NODE_COUNT),
    .TOKEN_COUNT(TOKEN_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
